FILE: rtl/core/parking_distance_indicator_macros.svh
// ============================================================================
// Parking distance indicator assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ============================================================================
`ifndef PARKING_DISTANCE_INDICATOR_MACROS_SVH
`define PARKING_DISTANCE_INDICATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PDI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PDI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pdi_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Parking distance indicator package
// Widths, register indexes, fixed thresholds, shared types and functions.
// ============================================================================
package pdi_pkg;

    // Field widths.
    localparam int ECHO_W   = 15;
    localparam int TIME_W   = 32;
    localparam int DIST_W   = 10;
    localparam int NEAR_W   = 9;
    localparam int FREQ_W   = 12;
    localparam int BAR_W    = 4;
    localparam int CLS_W    = 3;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 32;

    // Serial divider: 22-bit dividend covers the largest interpolation product.
    localparam int DIV_DW   = 22;
    localparam int DIV_VW   = 10;
    localparam int SUM_W    = 24;
    localparam int PER_W    = 23;

    // Configuration port.
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 12;
    localparam logic [CFG_AW-1:0] CFG_NEAR_CM        = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_FAR_CM         = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_FREQ_FAR_HZ    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_FREQ_NEAR_HZ   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_PERIOD_FAR_MS  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_PERIOD_NEAR_MS = 3'd5;

    // Register reset values.
    localparam int RST_NEAR_CM        = 10;
    localparam int RST_FAR_CM         = 120;
    localparam int RST_FREQ_FAR_HZ    = 250;
    localparam int RST_FREQ_NEAR_HZ   = 2200;
    localparam int RST_PERIOD_FAR_MS  = 600;
    localparam int RST_PERIOD_NEAR_MS = 80;

    // Fixed constants of the sensor.
    localparam int DIV_CM          = 58;
    localparam int ECHO_TIMEOUT_US = 30000;
    localparam int FREQ_MIN        = 200;
    localparam int FREQ_MAX        = 2500;
    localparam int FREQ_CRIT       = 2400;
    localparam int PERIOD_MIN      = 60;

    // Status classes.
    localparam logic [CLS_W-1:0] CLS_NONE       = 3'd0;
    localparam logic [CLS_W-1:0] CLS_DANGER     = 3'd1;
    localparam logic [CLS_W-1:0] CLS_VERY_CLOSE = 3'd2;
    localparam logic [CLS_W-1:0] CLS_APPROACH   = 3'd3;
    localparam logic [CLS_W-1:0] CLS_SAFE       = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CM,
        S_MUL,
        S_DIV,
        S_FIN,
        S_UPD,
        S_OUT
    } t_state;

    // Update request from the sequencer to the buzzer state.
    typedef struct packed {
        logic upd;
        logic echo;
        logic crit;
    } t_beep_cmd;

    function automatic logic [BAR_W-1:0] bar_of(input logic [DIST_W-1:0] cm);
        logic [BAR_W-1:0] lvl;
        if (cm > DIST_W'(80))      lvl = 4'd2;
        else if (cm > DIST_W'(60)) lvl = 4'd3;
        else if (cm > DIST_W'(45)) lvl = 4'd4;
        else if (cm > DIST_W'(30)) lvl = 4'd5;
        else if (cm > DIST_W'(20)) lvl = 4'd6;
        else if (cm > DIST_W'(10)) lvl = 4'd7;
        else                       lvl = 4'd8;
        return lvl;
    endfunction

    function automatic logic [CLS_W-1:0] class_of(input logic [DIST_W-1:0] cm);
        logic [CLS_W-1:0] cls;
        if (cm <= DIST_W'(10))      cls = CLS_DANGER;
        else if (cm <= DIST_W'(20)) cls = CLS_VERY_CLOSE;
        else if (cm <= DIST_W'(60)) cls = CLS_APPROACH;
        else                        cls = CLS_SAFE;
        return cls;
    endfunction

endpackage

FILE: rtl/core/pdi_sdiv.sv
`timescale 1ns / 1ps
// ============================================================================
// Bit-serial divider
// Restoring unsigned division, one quotient bit per clock.
// ============================================================================
module pdi_sdiv #(
    parameter int DW = pdi_pkg::DIV_DW,
    parameter int VW = pdi_pkg::DIV_VW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [VW-1:0] r_rem,  n_rem;
    logic [DW-1:0] r_q,    n_q;
    logic [VW-1:0] r_div,  n_div;

    logic [VW:0]   w_sh;
    logic [VW+1:0] w_trial;
    logic          w_fit;

    // The dividend shifts out of the top of r_q while quotient bits enter below.
    assign w_sh    = {r_rem, r_q[DW-1]};
    assign w_trial = {1'b0, w_sh} - {2'b00, r_div};
    assign w_fit   = !w_trial[VW+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_q    = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_fit ? w_trial[VW-1:0] : w_sh[VW-1:0];
            n_q   = {r_q[DW-2:0], w_fit};
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(DW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: rtl/core/pdi_beep.sv
`timescale 1ns / 1ps
// ============================================================================
// Buzzer state
// Holds the tone flag, the sounding frequency and the last toggle time.
// ============================================================================
module pdi_beep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pdi_pkg::t_beep_cmd            i_cmd,
    input  logic [pdi_pkg::TIME_W-1:0]    i_now,
    input  logic [pdi_pkg::PER_W-1:0]     i_period,
    input  logic [pdi_pkg::FREQ_W-1:0]    i_freq,
    output logic                          o_tone_on,
    output logic [pdi_pkg::FREQ_W-1:0]    o_freq
);

    logic [pdi_pkg::TIME_W-1:0] r_last, n_last;
    logic                       r_beep, n_beep;
    logic [pdi_pkg::FREQ_W-1:0] r_freq, n_freq;

    logic [pdi_pkg::TIME_W-1:0] w_elapsed;
    logic                       w_due;

    // Elapsed time wraps with the timestamp.
    assign w_elapsed = i_now - r_last;
    assign w_due     = w_elapsed >= pdi_pkg::TIME_W'(i_period);

    always_comb begin
        n_last = r_last;
        n_beep = r_beep;
        n_freq = r_freq;
        if (i_cmd.upd) begin
            if (!i_cmd.echo) begin
                n_beep = 1'b0;
            end else if (i_cmd.crit) begin
                n_beep = 1'b1;
                n_freq = pdi_pkg::FREQ_W'(pdi_pkg::FREQ_CRIT);
            end else if (w_due) begin
                n_last = i_now;
                n_beep = !r_beep;
                if (!r_beep) begin
                    n_freq = i_freq;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_beep <= 1'b0;
            r_freq <= '0;
        end else begin
            r_last <= n_last;
            r_beep <= n_beep;
            r_freq <= n_freq;
        end
    end

    assign o_tone_on = r_beep;
    assign o_freq    = r_freq;

endmodule

FILE: rtl/core/parking_distance_indicator.sv
`timescale 1ns / 1ps
// ============================================================================
// Parking distance indicator
// Turns an ultrasonic echo width into a distance, a bar level, a status class
// and buzzer tone state.
// ============================================================================
//
//  Channel  | Direction | Payload, lowest bits first
//  ---------+-----------+-------------------------------------------------------
//  s_axis   | in        | echo_width_us[14:0], now_ms[46:15], zero pad [47]
//  m_axis   | out       | distance_cm[9:0], bar_level[13:10], status_class[16:14],
//           |           | tone_on[17], tone_freq_hz[29:18], zero pad [31:30]
//  i_cfg_*  | in        | register index, write data (12 bits), write enable
//
// A word with a valid echo makes two passes through a 22-step bit-serial
// divider before the next ready, first for the centimeter distance and then
// for both interpolations side by side. A word without an echo skips the
// divider. The input is accepted only in idle.
// A finished word waits in the output register, so a stalled output delays
// the sequencer only once the next result is ready to be written there.
// Reset is synchronous and active low; it restores the register defaults and
// clears the buzzer state.
//
`include "parking_distance_indicator_macros.svh"

module parking_distance_indicator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input words.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // echo_width_us [14:0], now_ms [46:15], zero [47]
    input  logic [pdi_pkg::IN_W-1:0]         s_axis_tdata,
    // Result words.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // distance_cm [9:0], bar_level [13:10], status_class [16:14],
    // tone_on [17], tone_freq_hz [29:18], zero [31:30]
    output logic [pdi_pkg::OUT_W-1:0]        m_axis_tdata,
    // Configuration writes.
    input  logic                             i_cfg_we,
    input  logic [pdi_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  logic [pdi_pkg::CFG_DW-1:0]       i_cfg_wdata
);

    localparam int ECHO_W = pdi_pkg::ECHO_W;
    localparam int DIST_W = pdi_pkg::DIST_W;
    localparam int NEAR_W = pdi_pkg::NEAR_W;
    localparam int FREQ_W = pdi_pkg::FREQ_W;
    localparam int DIV_DW = pdi_pkg::DIV_DW;
    localparam int DIV_VW = pdi_pkg::DIV_VW;
    localparam int SUM_W  = pdi_pkg::SUM_W;
    localparam int PER_W  = pdi_pkg::PER_W;
    localparam int TIME_W = pdi_pkg::TIME_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NEAR_W-1:0] r_near;
    logic [DIST_W-1:0] r_far;
    logic [FREQ_W-1:0] r_freq_far, r_freq_near;
    logic [FREQ_W-1:0] r_per_far, r_per_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near      <= NEAR_W'(pdi_pkg::RST_NEAR_CM);
            r_far       <= DIST_W'(pdi_pkg::RST_FAR_CM);
            r_freq_far  <= FREQ_W'(pdi_pkg::RST_FREQ_FAR_HZ);
            r_freq_near <= FREQ_W'(pdi_pkg::RST_FREQ_NEAR_HZ);
            r_per_far   <= FREQ_W'(pdi_pkg::RST_PERIOD_FAR_MS);
            r_per_near  <= FREQ_W'(pdi_pkg::RST_PERIOD_NEAR_MS);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pdi_pkg::CFG_NEAR_CM:        r_near      <= i_cfg_wdata[NEAR_W-1:0];
                pdi_pkg::CFG_FAR_CM:         r_far       <= i_cfg_wdata[DIST_W-1:0];
                pdi_pkg::CFG_FREQ_FAR_HZ:    r_freq_far  <= i_cfg_wdata[FREQ_W-1:0];
                pdi_pkg::CFG_FREQ_NEAR_HZ:   r_freq_near <= i_cfg_wdata[FREQ_W-1:0];
                pdi_pkg::CFG_PERIOD_FAR_MS:  r_per_far   <= i_cfg_wdata[FREQ_W-1:0];
                pdi_pkg::CFG_PERIOD_NEAR_MS: r_per_near  <= i_cfg_wdata[FREQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic [ECHO_W-1:0] w_in_width;
    logic [TIME_W-1:0] w_in_now;
    logic              w_accept;
    logic              w_echo_ok;

    assign w_in_width = s_axis_tdata[ECHO_W-1:0];
    assign w_in_now   = s_axis_tdata[ECHO_W+TIME_W-1:ECHO_W];
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    // A zero width or one beyond the timeout means nothing came back.
    assign w_echo_ok  = (w_in_width != '0) &&
                        (w_in_width <= ECHO_W'(pdi_pkg::ECHO_TIMEOUT_US));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    pdi_pkg::t_state r_state, n_state;

    logic              r_echo;
    logic [DIST_W-1:0] r_cm;
    logic [TIME_W-1:0] r_now;
    logic [FREQ_W-1:0] r_fnew;
    logic [PER_W-1:0]  r_per;
    logic              r_out_valid;
    logic [pdi_pkg::OUT_W-1:0] r_out_data;

    logic              w_start_a, w_start_b;
    logic              w_done_a, w_done_b;
    logic [DIV_DW-1:0] w_quot_a, w_quot_b;
    logic [DIV_DW-1:0] w_dvd_a;
    logic [DIV_VW-1:0] w_dvs_a;
    logic              w_out_free;
    logic              w_load_out;

    assign w_out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state    = r_state;
        w_start_a  = 1'b0;
        w_start_b  = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            pdi_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_echo_ok) begin
                        w_start_a = 1'b1;
                        n_state   = pdi_pkg::S_CM;
                    end else begin
                        n_state = pdi_pkg::S_UPD;
                    end
                end
            end
            pdi_pkg::S_CM: begin
                if (w_done_a) begin
                    n_state = pdi_pkg::S_MUL;
                end
            end
            pdi_pkg::S_MUL: begin
                w_start_a = 1'b1;
                w_start_b = 1'b1;
                n_state   = pdi_pkg::S_DIV;
            end
            pdi_pkg::S_DIV: begin
                if (w_done_a) begin
                    n_state = pdi_pkg::S_FIN;
                end
            end
            pdi_pkg::S_FIN: begin
                n_state = pdi_pkg::S_UPD;
            end
            pdi_pkg::S_UPD: begin
                n_state = pdi_pkg::S_OUT;
            end
            pdi_pkg::S_OUT: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = pdi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pdi_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign s_axis_tready = (r_state == pdi_pkg::S_IDLE);

    // ------------------------------------------------------------------
    // Interpolation operands
    // The distance is clamped to 1..far, so d - far is never positive and
    // only the magnitudes go through the multiplier and the divider. The
    // sign of the quotient is restored afterwards, which truncates toward
    // zero just as a signed division does.
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] w_d_lo, w_d, w_dm;
    logic [FREQ_W-1:0] w_dy_f, w_dy_p;
    logic [DIV_VW-1:0] w_den_mag;
    logic              w_near_lt_far, w_den_zero;
    logic [DIV_DW-1:0] w_prod_f, w_prod_p;

    assign w_d_lo        = (r_cm == '0) ? DIST_W'(1) : r_cm;
    assign w_d           = (w_d_lo > r_far) ? r_far : w_d_lo;
    assign w_dm          = r_far - w_d;
    assign w_dy_f        = (r_freq_near >= r_freq_far) ? (r_freq_near - r_freq_far)
                                                       : (r_freq_far - r_freq_near);
    assign w_dy_p        = (r_per_near >= r_per_far) ? (r_per_near - r_per_far)
                                                     : (r_per_far - r_per_near);
    assign w_near_lt_far = (DIST_W'(r_near) < r_far);
    assign w_den_zero    = (DIST_W'(r_near) == r_far);
    assign w_den_mag     = w_near_lt_far ? (r_far - DIST_W'(r_near))
                                         : (DIST_W'(r_near) - r_far);
    assign w_prod_f      = DIV_DW'(w_dm) * DIV_DW'(w_dy_f);
    assign w_prod_p      = DIV_DW'(w_dm) * DIV_DW'(w_dy_p);

    // Divider A first turns the echo width into centimeters, then takes the
    // frequency quotient; divider B takes the period quotient alongside.
    assign w_dvd_a = (r_state == pdi_pkg::S_IDLE) ? DIV_DW'(w_in_width) : w_prod_f;
    assign w_dvs_a = (r_state == pdi_pkg::S_IDLE) ? DIV_VW'(pdi_pkg::DIV_CM) : w_den_mag;

    pdi_sdiv #(
        .DW (DIV_DW),
        .VW (DIV_VW)
    ) u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start_a),
        .i_dividend (w_dvd_a),
        .i_divisor  (w_dvs_a),
        .o_done     (w_done_a),
        .o_quot     (w_quot_a)
    );

    pdi_sdiv #(
        .DW (DIV_DW),
        .VW (DIV_VW)
    ) u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start_b),
        .i_dividend (w_prod_p),
        .i_divisor  (w_den_mag),
        .o_done     (w_done_b),
        .o_quot     (w_quot_b)
    );

    // ------------------------------------------------------------------
    // Sign, offset and clamp of both interpolations
    // With equal ends the quotient is dropped and the far-end value stands.
    // ------------------------------------------------------------------
    logic                    w_neg_f, w_neg_p;
    logic [DIV_DW-1:0]       w_qf, w_qp;
    logic signed [SUM_W-1:0] w_sq_f, w_sq_p, w_f, w_p;
    logic [FREQ_W-1:0]       w_freq_c;
    logic [PER_W-1:0]        w_per_c;

    assign w_neg_f = (r_freq_near >= r_freq_far) ^ w_near_lt_far;
    assign w_neg_p = (r_per_near >= r_per_far) ^ w_near_lt_far;
    assign w_qf    = w_den_zero ? '0 : w_quot_a;
    assign w_qp    = w_den_zero ? '0 : w_quot_b;
    assign w_sq_f  = w_neg_f ? -$signed(SUM_W'(w_qf)) : $signed(SUM_W'(w_qf));
    assign w_sq_p  = w_neg_p ? -$signed(SUM_W'(w_qp)) : $signed(SUM_W'(w_qp));
    assign w_f     = w_sq_f + $signed(SUM_W'(r_freq_far));
    assign w_p     = w_sq_p + $signed(SUM_W'(r_per_far));

    assign w_freq_c = (w_f < $signed(SUM_W'(pdi_pkg::FREQ_MIN))) ?
                          FREQ_W'(pdi_pkg::FREQ_MIN) :
                      (w_f > $signed(SUM_W'(pdi_pkg::FREQ_MAX))) ?
                          FREQ_W'(pdi_pkg::FREQ_MAX) : w_f[FREQ_W-1:0];
    assign w_per_c  = (w_p < $signed(SUM_W'(pdi_pkg::PERIOD_MIN))) ?
                          PER_W'(pdi_pkg::PERIOD_MIN) : w_p[PER_W-1:0];

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_echo <= w_echo_ok;
            r_now  <= w_in_now;
            r_cm   <= '0;
        end else if (r_state == pdi_pkg::S_CM && w_done_a) begin
            r_cm <= w_quot_a[DIST_W-1:0];
        end
        if (r_state == pdi_pkg::S_FIN) begin
            r_fnew <= w_freq_c;
            r_per  <= w_per_c;
        end
    end

    // ------------------------------------------------------------------
    // Buzzer state
    // ------------------------------------------------------------------
    pdi_pkg::t_beep_cmd        w_beep_cmd;
    logic                      w_tone_on;
    logic [FREQ_W-1:0]         w_tone_freq;

    assign w_beep_cmd.upd  = (r_state == pdi_pkg::S_UPD);
    assign w_beep_cmd.echo = r_echo;
    assign w_beep_cmd.crit = (r_cm <= DIST_W'(r_near));

    pdi_beep u_beep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_beep_cmd),
        .i_now     (r_now),
        .i_period  (r_per),
        .i_freq    (r_fnew),
        .o_tone_on (w_tone_on),
        .o_freq    (w_tone_freq)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [pdi_pkg::BAR_W-1:0] w_bar;
    logic [pdi_pkg::CLS_W-1:0] w_cls;

    assign w_bar = r_echo ? pdi_pkg::bar_of(r_cm) : '0;
    assign w_cls = r_echo ? pdi_pkg::class_of(r_cm) : pdi_pkg::CLS_NONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= {2'b00, w_tone_freq, w_tone_on, w_cls, w_bar, r_cm};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PDI_ASSERT_IMP(a_div_lockstep, (r_state == pdi_pkg::S_DIV) && w_done_a, w_done_b, "interpolation dividers out of step")
    `PDI_ASSERT_IMP(a_tone_freq_set, m_axis_tvalid && m_axis_tdata[17], m_axis_tdata[29:18] >= FREQ_W'(pdi_pkg::FREQ_MIN), "tone on without a set frequency")
    `PDI_ASSERT_IMP(a_bar_class, m_axis_tvalid, (m_axis_tdata[16:14] == pdi_pkg::CLS_NONE) == (m_axis_tdata[13:10] == '0), "bar level and status class disagree")
    `PDI_ASSERT_NXT(a_crit_tone, w_beep_cmd.upd && r_echo && w_beep_cmd.crit, w_tone_on && (w_tone_freq == FREQ_W'(pdi_pkg::FREQ_CRIT)), "critical zone without continuous tone")

endmodule

FILE: test/tb_parking_distance_indicator.sv
`timescale 1ns / 1ps
// ============================================================================
// Parking distance indicator testbench
// Drives echo words through the stream input and checks every result word
// against an in-bench prediction of distance, bar level, status class and
// buzzer state. It covers directed edge cases, several register settings and
// randomized traffic with bursty input and stalling output.
// ============================================================================
module tb_parking_distance_indicator;
    import pdi_pkg::*;

    // Register indexes that the block does not decode; writes must be ignored.
    localparam logic [CFG_AW-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_SPARE_7 = 3'd7;

    localparam int WORDS_PER_PHASE = 150;
    localparam int SETTLE_CYCLES   = 60;

    // One result word, highest field first so the struct maps onto tdata.
    typedef struct packed {
        logic [1:0]        pad;
        logic [FREQ_W-1:0] freq;
        logic              tone;
        logic [CLS_W-1:0]  cls;
        logic [BAR_W-1:0]  bar;
        logic [DIST_W-1:0] dist_cm;
    } t_reading;

    typedef enum {STALL_NONE, STALL_HALF, STALL_RARE, STALL_HEAVY} t_stall_mode;

    // Predicts the sensor readings and buzzer state and checks result words.
    class pdi_board;
        int unsigned near_cm, far_cm, freq_far_hz, freq_near_hz;
        int unsigned period_far_ms, period_near_ms;
        logic [TIME_W-1:0] last_toggle_ms;
        logic              beep_on;
        logic [FREQ_W-1:0] sounding_freq;
        t_reading          pending_readings[$];
        int unsigned       mismatches, readings_checked, toggles;

        function new();
            near_cm        = RST_NEAR_CM;
            far_cm         = RST_FAR_CM;
            freq_far_hz    = RST_FREQ_FAR_HZ;
            freq_near_hz   = RST_FREQ_NEAR_HZ;
            period_far_ms  = RST_PERIOD_FAR_MS;
            period_near_ms = RST_PERIOD_NEAR_MS;
            last_toggle_ms = '0;
            beep_on        = 1'b0;
            sounding_freq  = '0;
            mismatches       = 0;
            readings_checked = 0;
            toggles          = 0;
        endfunction

        function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_NEAR_CM:        near_cm        = val[NEAR_W-1:0];
                CFG_FAR_CM:         far_cm         = val[DIST_W-1:0];
                CFG_FREQ_FAR_HZ:    freq_far_hz    = val;
                CFG_FREQ_NEAR_HZ:   freq_near_hz   = val;
                CFG_PERIOD_FAR_MS:  period_far_ms  = val;
                CFG_PERIOD_NEAR_MS: period_near_ms = val;
                default: ;
            endcase
        endfunction

        // Linear interpolation with truncation toward zero; equal ends give y0.
        function longint interp(longint x, longint x0, longint x1, longint y0,
                                longint y1);
            if (x1 == x0)
                return y0;
            return (x - x0) * (y1 - y0) / (x1 - x0) + y0;
        endfunction

        function logic [BAR_W-1:0] bar_for(int unsigned cm);
            if (cm > 80) return 4'd2;
            if (cm > 60) return 4'd3;
            if (cm > 45) return 4'd4;
            if (cm > 30) return 4'd5;
            if (cm > 20) return 4'd6;
            if (cm > 10) return 4'd7;
            return 4'd8;
        endfunction

        function void note_echo(logic [ECHO_W-1:0] width_us, logic [TIME_W-1:0] now_ms);
            t_reading          r;
            int unsigned       cm;
            longint            d, f, p, gap_ms;
            logic [TIME_W-1:0] elapsed;
            r = '0;
            if (width_us == 0 || width_us > ECHO_TIMEOUT_US) begin
                beep_on = 1'b0;
            end else begin
                cm        = width_us / DIV_CM;
                r.dist_cm = DIST_W'(cm);
                r.bar     = bar_for(cm);
                if (cm <= 10)      r.cls = CLS_DANGER;
                else if (cm <= 20) r.cls = CLS_VERY_CLOSE;
                else if (cm <= 60) r.cls = CLS_APPROACH;
                else               r.cls = CLS_SAFE;

                d = cm;
                if (d < 1) d = 1;
                if (d > far_cm) d = far_cm;
                f = interp(d, far_cm, near_cm, freq_far_hz, freq_near_hz);
                if (f < FREQ_MIN) f = FREQ_MIN;
                if (f > FREQ_MAX) f = FREQ_MAX;
                p = interp(d, far_cm, near_cm, period_far_ms, period_near_ms);
                if (p < PERIOD_MIN) p = PERIOD_MIN;

                elapsed = now_ms - last_toggle_ms;
                gap_ms  = longint'({32'd0, elapsed});
                if (cm <= near_cm) begin
                    // Critical zone: steady tone, toggle time untouched.
                    beep_on       = 1'b1;
                    sounding_freq = FREQ_W'(FREQ_CRIT);
                end else if (gap_ms >= p) begin
                    last_toggle_ms = now_ms;
                    beep_on        = !beep_on;
                    toggles++;
                    if (beep_on)
                        sounding_freq = FREQ_W'(f);
                end
            end
            r.tone = beep_on;
            r.freq = sounding_freq;
            pending_readings.push_back(r);
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_reading(logic [OUT_W-1:0] word);
            t_reading want, got;
            got = word;
            if (pending_readings.size() == 0) begin
                $display("%0t: result word %h arrived with no reading pending, expected none, actual %h",
                         $time, word, word);
                mismatches++;
                return;
            end
            want = pending_readings.pop_front();
            readings_checked++;
            if (got.dist_cm !== want.dist_cm) report("distance_cm", want.dist_cm, got.dist_cm);
            if (got.bar  !== want.bar)  report("bar_level", want.bar, got.bar);
            if (got.cls  !== want.cls)  report("status_class", want.cls, got.cls);
            if (got.tone !== want.tone) report("tone_on", want.tone, got.tone);
            if (got.freq !== want.freq) report("tone_freq_hz", want.freq, got.freq);
            if (got.pad  !== want.pad)  report("zero pad", want.pad, got.pad);
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr    = '0;
    logic [CFG_DW-1:0] i_cfg_wdata   = '0;

    pdi_board          board;
    int unsigned       burst_left    = 0;
    int unsigned       words_sent    = 0;
    int unsigned       settings_used = 0;
    logic [TIME_W-1:0] clock_ms      = '0;

    parking_distance_indicator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result words are sampled at the edge where they are taken.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_reading(m_axis_tdata);
    end

    // The receiver switches between stretches of steady acceptance and
    // stretches of light or heavy back-pressure.
    initial begin
        t_stall_mode mode;
        int unsigned span;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(16, 300);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    STALL_NONE: m_axis_tready <= 1'b1;
                    STALL_HALF: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    STALL_RARE: m_axis_tready <= ($urandom_range(0, 9) != 0);
                    default:    m_axis_tready <= ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    // Offers one word and waits for the edge where it is taken; at the end of a
    // burst the sender then drops valid before it returns.
    task automatic send_word(input logic [ECHO_W-1:0] width_us,
                             input logic [TIME_W-1:0] now_ms);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, now_ms, width_us};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_echo(width_us, now_ms);
        words_sent++;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 70)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    // Holds the input off until every pending reading has come back.
    task automatic wait_drained();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= CFG_DW'(val);
        @(posedge i_clk);
        board.write_reg(idx, CFG_DW'(val));
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input int unsigned near, input int unsigned far,
                                 input int unsigned ffar, input int unsigned fnear,
                                 input int unsigned pfar, input int unsigned pnear);
        write_reg(CFG_NEAR_CM, near);
        write_reg(CFG_FAR_CM, far);
        write_reg(CFG_FREQ_FAR_HZ, ffar);
        write_reg(CFG_FREQ_NEAR_HZ, fnear);
        write_reg(CFG_PERIOD_FAR_MS, pfar);
        write_reg(CFG_PERIOD_NEAR_MS, pnear);
        settings_used++;
    endtask

    // Mostly plausible echoes around the configured zone with a clock that
    // advances by realistic steps; the rest is no-echo, threshold hits and
    // raw random widths and times.
    task automatic send_traffic(input int unsigned count);
        int unsigned       span, cm, pick;
        logic [ECHO_W-1:0] width_us;
        int unsigned       marks [16];
        span = ((board.far_cm > board.near_cm) ? board.far_cm : board.near_cm) + 40;
        if (span > 517) span = 517;
        marks = '{10, 11, 20, 21, 30, 31, 45, 46, 60, 61, 80, 81,
                  board.near_cm, board.near_cm + 1, board.far_cm, board.far_cm + 1};
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                cm       = $urandom_range(0, span);
                width_us = ECHO_W'(cm * DIV_CM + $urandom_range(0, DIV_CM - 1));
            end else if (pick == 7) begin
                width_us = ($urandom_range(0, 1) == 0) ? ECHO_W'(0)
                                                       : ECHO_W'($urandom_range(30001, 32767));
            end else if (pick == 8) begin
                width_us = ECHO_W'($urandom_range(0, 32767));
            end else begin
                width_us = ECHO_W'(marks[$urandom_range(0, 15)] * DIV_CM);
            end

            if ($urandom_range(0, 49) == 0)
                clock_ms = $urandom;
            else if ($urandom_range(0, 3) == 0)
                clock_ms = clock_ms + $urandom_range(0, 5000);
            else
                clock_ms = clock_ms + $urandom_range(0, 400);
            send_word(width_us, clock_ms);
        end
    endtask

    initial begin
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset defaults: no echo, sub-centimeter, both
        // sides of every bar and class boundary but 30 cm, the far clamp, the timeout
        // edge and toggling across the wrap of the millisecond clock.
        send_word(15'd0,     32'd0);
        send_word(15'd1,     32'd100);
        send_word(15'd57,    32'd200);
        send_word(15'd58,    32'd300);
        send_word(15'd580,   32'd400);
        send_word(15'd638,   32'd500);
        send_word(15'd1160,  32'd1100);
        send_word(15'd1218,  32'd1150);
        send_word(15'd1798,  32'd1900);
        send_word(15'd2610,  32'd2000);
        send_word(15'd2668,  32'd2800);
        send_word(15'd3480,  32'd3600);
        send_word(15'd3538,  32'd3650);
        send_word(15'd4640,  32'd4500);
        send_word(15'd4698,  32'd5300);
        send_word(15'd6960,  32'd6000);
        send_word(15'd7018,  32'd7000);
        send_word(15'd30000, 32'd8000);
        send_word(15'd30001, 32'd8100);
        send_word(15'd32767, 32'd8200);
        send_word(15'd7018,  32'hFFFF_FF00);
        send_word(15'd7018,  32'h0000_0200);
        send_word(15'd7018,  32'h0000_0300);
        send_word(15'd3000,  32'hFFFF_FFFF);
        wait_drained();

        // Register extremes: widest span with full-scale tone and period slopes.
        apply_setting(1, 564, 0, 4095, 4095, 0);
        send_traffic(WORDS_PER_PHASE);
        wait_drained();

        // Near above far, with the clock about to wrap.
        clock_ms = 32'hFFFF_F000;
        apply_setting(500, 2, 4095, 0, 0, 4095);
        send_traffic(WORDS_PER_PHASE);
        wait_drained();

        // Equal ends fall back to the far-end values.
        apply_setting(100, 100, $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
        send_traffic(WORDS_PER_PHASE);
        wait_drained();

        apply_setting(500, 564, 200, 2500, 60, 61);
        send_traffic(WORDS_PER_PHASE);
        wait_drained();

        // Writes to undecoded indexes must leave every register alone.
        write_reg(CFG_SPARE_6, $urandom_range(0, 4095));
        write_reg(CFG_SPARE_7, $urandom_range(0, 4095));
        begin
            int unsigned near;
            near = $urandom_range(1, 200);
            apply_setting(near, $urandom_range(near + 1, 564), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095));
        end
        send_traffic(WORDS_PER_PHASE);
        wait_drained();

        apply_setting($urandom_range(1, 500), $urandom_range(2, 564),
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
        send_traffic(WORDS_PER_PHASE);
        wait_drained();

        apply_setting(RST_NEAR_CM, RST_FAR_CM, RST_FREQ_FAR_HZ, RST_FREQ_NEAR_HZ,
                      RST_PERIOD_FAR_MS, RST_PERIOD_NEAR_MS);
        send_traffic(WORDS_PER_PHASE);
        wait_drained();

        $display("Run covered %0d echo words over %0d register settings plus defaults.",
                 words_sent, settings_used);
        $display("Checked %0d readings, %0d buzzer toggles, %0d mismatches.",
                 board.readings_checked, board.toggles, board.mismatches);
        if (board.mismatches == 0 && board.pending_readings.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
